@@ rtl/rsl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsl_pkg: shared definitions for the rectangle subtraction pipeline
// Field widths, coordinate slot indexes, strip indexes and the flag bundle
// that travels down the pipeline with each rectangle pair.
// ----------------------------------------------------------------------------
package rsl_pkg;

  localparam int unsigned FieldWidth        = 32;
  localparam int unsigned CoordWidthDefault = 32;
  localparam int unsigned NumCoords         = 8;
  localparam int unsigned NumSides          = 4;

  // Coordinate slots in the packed coordinate vector.
  localparam int unsigned IdxAl = 0;
  localparam int unsigned IdxAt = 1;
  localparam int unsigned IdxAr = 2;
  localparam int unsigned IdxAb = 3;
  localparam int unsigned IdxBl = 4;
  localparam int unsigned IdxBt = 5;
  localparam int unsigned IdxBr = 6;
  localparam int unsigned IdxBb = 7;

  // Edge strips of A; on equal scores the later strip in this order wins.
  localparam int unsigned SideLeft   = 0;
  localparam int unsigned SideRight  = 1;
  localparam int unsigned SideTop    = 2;
  localparam int unsigned SideBottom = 3;

  typedef struct packed {
    logic                pass;     // A is returned unchanged
    logic                covered;  // B covers A, result is empty
    logic [NumSides-1:0] pos;      // strip has positive depth
  } rsl_flags_t;

endpackage

@@ rtl/rsl_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsl_if: input and output channels of the rectangle subtraction block
// Valid/ready channels; a transfer happens on a clock edge where both are high.
// ----------------------------------------------------------------------------
interface rsl_in_if
  import rsl_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic signed [FieldWidth-1:0] a_left;
  logic signed [FieldWidth-1:0] a_top;
  logic signed [FieldWidth-1:0] a_right;
  logic signed [FieldWidth-1:0] a_bottom;
  logic signed [FieldWidth-1:0] b_left;
  logic signed [FieldWidth-1:0] b_top;
  logic signed [FieldWidth-1:0] b_right;
  logic signed [FieldWidth-1:0] b_bottom;

  modport source (
    output valid, a_left, a_top, a_right, a_bottom, b_left, b_top, b_right, b_bottom,
    input  ready
  );
  modport sink (
    input  valid, a_left, a_top, a_right, a_bottom, b_left, b_top, b_right, b_bottom,
    output ready
  );
endinterface

interface rsl_out_if
  import rsl_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic signed [FieldWidth-1:0] out_left;
  logic signed [FieldWidth-1:0] out_top;
  logic signed [FieldWidth-1:0] out_right;
  logic signed [FieldWidth-1:0] out_bottom;
  logic                         exact;

  modport source (
    output valid, out_left, out_top, out_right, out_bottom, exact,
    input  ready
  );
  modport sink (
    input  valid, out_left, out_top, out_right, out_bottom, exact,
    output ready
  );
endinterface

@@ rtl/rect_subtract_largest_remainder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_subtract_largest_remainder: largest part of rectangle A outside B
// Returns the largest edge strip of A outside B, A itself if B misses A, or
// zeros if B covers A, with a flag telling whether it is exactly A minus B.
// ----------------------------------------------------------------------------
// The block takes one rectangle pair per clock cycle while the output is not
// stalled and returns the results in order. Each pair passes through the
// three register stages: coordinate decode and strip depths, one multiplier
// per strip for the area scores, and the score compare that loads the output
// register. Backpressure on the output stalls the stages from the back, and
// each stage refills as soon as the one behind it moves, so a steady flow
// keeps one transfer per cycle on both sides. Coordinates are the low
// COORD_WIDTH bits of each field read as two's complement, and results are
// sign-extended back to the full field width.
module rect_subtract_largest_remainder
  import rsl_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rsl_in_if.sink    in_i,
  rsl_out_if.source out_o
);

  localparam int unsigned ProdWidth = 2 * COORD_WIDTH;

  logic                                  p_valid, p_ready;
  rsl_flags_t                            p_flags;
  logic [NumCoords-1:0][COORD_WIDTH-1:0] p_coords;
  logic [COORD_WIDTH-1:0]                p_width, p_height;
  logic [NumSides-1:0][COORD_WIDTH-1:0]  p_depth;

  logic                                  m_valid, m_ready;
  rsl_flags_t                            m_flags;
  logic [NumCoords-1:0][COORD_WIDTH-1:0] m_coords;
  logic [NumSides-1:0][ProdWidth-1:0]    m_score;

  rsl_prep #(
    .CoordWidth(COORD_WIDTH)
  ) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .valid_o  (p_valid),
    .ready_i  (p_ready),
    .flags_o  (p_flags),
    .coords_o (p_coords),
    .width_o  (p_width),
    .height_o (p_height),
    .depth_o  (p_depth)
  );

  rsl_mult #(
    .CoordWidth(COORD_WIDTH)
  ) u_mult (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (p_valid),
    .ready_o  (p_ready),
    .flags_i  (p_flags),
    .coords_i (p_coords),
    .width_i  (p_width),
    .height_i (p_height),
    .depth_i  (p_depth),
    .valid_o  (m_valid),
    .ready_i  (m_ready),
    .flags_o  (m_flags),
    .coords_o (m_coords),
    .score_o  (m_score)
  );

  rsl_pick #(
    .CoordWidth(COORD_WIDTH)
  ) u_pick (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (m_valid),
    .ready_o  (m_ready),
    .flags_i  (m_flags),
    .coords_i (m_coords),
    .score_i  (m_score),
    .out_o    (out_o)
  );

`ifndef SYNTHESIS
  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> p_valid && m_valid && out_o.valid && !out_o.ready)
    else $error("rect_subtract_largest_remainder: input stalled with room in the pipeline");

  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid && !m_ready |=> m_valid && $stable(m_score) && $stable(m_flags))
    else $error("rect_subtract_largest_remainder: stalled score stage lost its item");
`endif

endmodule

@@ rtl/rsl_prep.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsl_prep: first pipeline stage
// Decodes coordinates, classifies the pair and computes side lengths of A and
// the depths of the left, right, top and bottom edge strips.
// ----------------------------------------------------------------------------
module rsl_prep
  import rsl_pkg::*;
#(
  parameter int unsigned CoordWidth = CoordWidthDefault
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  rsl_in_if.sink                                   in_i,
  output logic                                     valid_o,
  input  logic                                     ready_i,
  output rsl_flags_t                               flags_o,
  output logic [NumCoords-1:0][CoordWidth-1:0]     coords_o,
  output logic [CoordWidth-1:0]                    width_o,
  output logic [CoordWidth-1:0]                    height_o,
  output logic [NumSides-1:0][CoordWidth-1:0]      depth_o
);

  logic signed [CoordWidth-1:0] al, at, ar, ab, bl, bt, br, bb;
  logic signed [CoordWidth-1:0] il, it, ir, ib;
  logic                         a_empty, b_empty, meet;

  logic                                 valid_q;
  rsl_flags_t                           flags_d, flags_q;
  logic [NumCoords-1:0][CoordWidth-1:0] coords_d, coords_q;
  logic [CoordWidth-1:0]                width_d, width_q, height_d, height_q;
  logic [NumSides-1:0][CoordWidth-1:0]  depth_d, depth_q;

  assign al = signed'(in_i.a_left[CoordWidth-1:0]);
  assign at = signed'(in_i.a_top[CoordWidth-1:0]);
  assign ar = signed'(in_i.a_right[CoordWidth-1:0]);
  assign ab = signed'(in_i.a_bottom[CoordWidth-1:0]);
  assign bl = signed'(in_i.b_left[CoordWidth-1:0]);
  assign bt = signed'(in_i.b_top[CoordWidth-1:0]);
  assign br = signed'(in_i.b_right[CoordWidth-1:0]);
  assign bb = signed'(in_i.b_bottom[CoordWidth-1:0]);

  assign in_i.ready = !valid_q || ready_i;

  always_comb begin
    a_empty = (ar <= al) || (ab <= at);
    b_empty = (br <= bl) || (bb <= bt);
    il      = (al > bl) ? al : bl;
    ir      = (ar < br) ? ar : br;
    it      = (at > bt) ? at : bt;
    ib      = (ab < bb) ? ab : bb;
    meet    = (il < ir) && (it < ib);

    flags_d.pass                = a_empty || b_empty || !meet;
    flags_d.pos[SideLeft]       = bl > al;
    flags_d.pos[SideRight]      = ar > br;
    flags_d.pos[SideTop]        = bt > at;
    flags_d.pos[SideBottom]     = ab > bb;
    flags_d.covered             = (flags_d.pos == '0);

    width_d  = ar - al;
    height_d = ab - at;
    depth_d[SideLeft]   = flags_d.pos[SideLeft]   ? CoordWidth'(bl - al) : '0;
    depth_d[SideRight]  = flags_d.pos[SideRight]  ? CoordWidth'(ar - br) : '0;
    depth_d[SideTop]    = flags_d.pos[SideTop]    ? CoordWidth'(bt - at) : '0;
    depth_d[SideBottom] = flags_d.pos[SideBottom] ? CoordWidth'(ab - bb) : '0;

    coords_d[IdxAl] = al;
    coords_d[IdxAt] = at;
    coords_d[IdxAr] = ar;
    coords_d[IdxAb] = ab;
    coords_d[IdxBl] = bl;
    coords_d[IdxBt] = bt;
    coords_d[IdxBr] = br;
    coords_d[IdxBb] = bb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      flags_q  <= flags_d;
      coords_q <= coords_d;
      width_q  <= width_d;
      height_q <= height_d;
      depth_q  <= depth_d;
    end
  end

  assign valid_o  = valid_q;
  assign flags_o  = flags_q;
  assign coords_o = coords_q;
  assign width_o  = width_q;
  assign height_o = height_q;
  assign depth_o  = depth_q;

`ifndef SYNTHESIS
  a_prep_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q && $stable(flags_q) && $stable(depth_q))
    else $error("rsl_prep: stalled stage lost or changed its item");
`endif

endmodule

@@ rtl/rsl_mult.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsl_mult: second pipeline stage
// Scores each strip by cross-multiplying its depth with the opposite side
// length of A, one multiplier per strip.
// ----------------------------------------------------------------------------
module rsl_mult
  import rsl_pkg::*;
#(
  parameter int unsigned CoordWidth = CoordWidthDefault,
  localparam int unsigned ProdWidth = 2 * CoordWidth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  rsl_flags_t                           flags_i,
  input  logic [NumCoords-1:0][CoordWidth-1:0] coords_i,
  input  logic [CoordWidth-1:0]                width_i,
  input  logic [CoordWidth-1:0]                height_i,
  input  logic [NumSides-1:0][CoordWidth-1:0]  depth_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output rsl_flags_t                           flags_o,
  output logic [NumCoords-1:0][CoordWidth-1:0] coords_o,
  output logic [NumSides-1:0][ProdWidth-1:0]   score_o
);

  logic                                 valid_q;
  rsl_flags_t                           flags_q;
  logic [NumCoords-1:0][CoordWidth-1:0] coords_q;
  logic [NumSides-1:0][ProdWidth-1:0]   score_d, score_q;

  assign ready_o = !valid_q || ready_i;

  // Left and right strips scale with the height of A, top and bottom ones with its width.
  always_comb begin
    score_d[SideLeft]   = ProdWidth'(depth_i[SideLeft])   * ProdWidth'(height_i);
    score_d[SideRight]  = ProdWidth'(depth_i[SideRight])  * ProdWidth'(height_i);
    score_d[SideTop]    = ProdWidth'(depth_i[SideTop])    * ProdWidth'(width_i);
    score_d[SideBottom] = ProdWidth'(depth_i[SideBottom]) * ProdWidth'(width_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      flags_q  <= flags_i;
      coords_q <= coords_i;
      score_q  <= score_d;
    end
  end

  assign valid_o  = valid_q;
  assign flags_o  = flags_q;
  assign coords_o = coords_q;
  assign score_o  = score_q;

endmodule

@@ rtl/rsl_pick.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsl_pick: final pipeline stage
// Compares the strip scores with bottom, top, right, left priority on ties,
// forms the remaining rectangle and holds it in the output register.
// ----------------------------------------------------------------------------
module rsl_pick
  import rsl_pkg::*;
#(
  parameter int unsigned CoordWidth = CoordWidthDefault,
  localparam int unsigned ProdWidth = 2 * CoordWidth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  rsl_flags_t                           flags_i,
  input  logic [NumCoords-1:0][CoordWidth-1:0] coords_i,
  input  logic [NumSides-1:0][ProdWidth-1:0]   score_i,
  rsl_out_if.source                            out_o
);

  logic signed [CoordWidth-1:0] al, at, ar, ab, bl, bt, br, bb;
  logic signed [CoordWidth-1:0] ol, ot, orr, ob;
  logic [ProdWidth-1:0]         sl, sr, st, sb;
  logic                         exact_d;

  logic                         valid_q, exact_q;
  logic signed [FieldWidth-1:0] left_d, top_d, right_d, bottom_d;
  logic signed [FieldWidth-1:0] left_q, top_q, right_q, bottom_q;

  assign ready_o = !valid_q || out_o.ready;

  assign al = signed'(coords_i[IdxAl]);
  assign at = signed'(coords_i[IdxAt]);
  assign ar = signed'(coords_i[IdxAr]);
  assign ab = signed'(coords_i[IdxAb]);
  assign bl = signed'(coords_i[IdxBl]);
  assign bt = signed'(coords_i[IdxBt]);
  assign br = signed'(coords_i[IdxBr]);
  assign bb = signed'(coords_i[IdxBb]);

  assign sl = score_i[SideLeft];
  assign sr = score_i[SideRight];
  assign st = score_i[SideTop];
  assign sb = score_i[SideBottom];

  always_comb begin
    ol      = al;
    ot      = at;
    orr     = ar;
    ob      = ab;
    exact_d = 1'b1;
    if (!flags_i.pass) begin
      if (flags_i.covered) begin
        ol  = '0;
        ot  = '0;
        orr = '0;
        ob  = '0;
      end else begin
        if (sl > sr && sl > st && sl > sb) begin
          orr = bl;
        end else if (sr > st && sr > sb) begin
          ol = br;
        end else if (st > sb) begin
          ob = bt;
        end else begin
          ot = bb;
        end
        exact_d = ($countones(flags_i.pos) == 1);
      end
    end
    left_d   = FieldWidth'(ol);
    top_d    = FieldWidth'(ot);
    right_d  = FieldWidth'(orr);
    bottom_d = FieldWidth'(ob);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      left_q   <= left_d;
      top_q    <= top_d;
      right_q  <= right_d;
      bottom_q <= bottom_d;
      exact_q  <= exact_d;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.out_left   = left_q;
  assign out_o.out_top    = top_q;
  assign out_o.out_right  = right_q;
  assign out_o.out_bottom = bottom_q;
  assign out_o.exact      = exact_q;

`ifndef SYNTHESIS
  a_pick_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !exact_q |-> (right_q > left_q) && (bottom_q > top_q))
    else $error("rsl_pick: inexact result is an empty rectangle");
`endif

endmodule
